/* rtl/core/dftk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dftk_pkg;

	localparam int KEY_W    = 16;
	localparam int TICKET_W = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

	// one queue slot: key plus its ticket
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [TICKET_W-1:0] ticket;
	} entry_t;

	// outcome of a key search
	typedef struct packed {
		logic                done;
		logic                hit;
		logic [TICKET_W-1:0] ticket;
	} scan_res_t;

endpackage
`default_nettype wire

/* rtl/core/dftk_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface dftk_req_if;
	import dftk_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [KEY_W-1:0] key;

	modport source (output valid, output cmd, output key, input ready);
	modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface dftk_rsp_if;
	import dftk_pkg::*;

	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    front_key;
	logic                front_valid;
	logic [TICKET_W-1:0] ticket;
	logic                found;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output front_key, output front_valid, output ticket,
		output found, output status, output count, input ready);
	modport sink   (input valid, input front_key, input front_valid, input ticket,
		input found, input status, input count, output ready);
endinterface
`default_nettype wire

/* rtl/core/dedup_fifo_with_tickets_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Queue of unique keys, each holding a ticket number.
// req channel (valid/ready): cmd and key. add enqueues an absent key with the
// next ticket (1 after reset, wraps at 32 bits); remove drops the front;
// peek reports the front; query looks up a key's ticket.
// rsp channel (valid/ready): one item per request with the front key after
// the step, the ticket and found flag, a status code and the fill count.
// Timing: one request at a time. Add and query search the waiting keys one
// per cycle through the shared compare unit and the storage read port,
// stopping at a hit. Each request then passes the update, front read,
// front wait and output states; remove and peek skip the search. When the
// queue is empty after the step, the front wait state is skipped.
// The front key is re-read from storage at the end of every request.
// Reset: queue empty, next ticket 1; storage contents are not cleared, only
// data from slots inside the occupied window is ever used.
// Stall: the result sits in an output register; a new request is taken while
// it waits, but the next result is held back until rsp.ready frees it.
module dedup_fifo_with_tickets_unit #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dftk_req_if.sink   req,
	dftk_rsp_if.source rsp
);
	import dftk_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((33'd1 << KB) - 33'd1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_UPDATE  = 3'd2;
	localparam logic [2:0] ST_FRONT_RD = 3'd3;
	localparam logic [2:0] ST_FRONT_WT = 3'd4;
	localparam logic [2:0] ST_OUT     = 3'd5;

	logic [2:0]          state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       tail_q;
	logic [CW-1:0]       fill_q;
	logic [TICKET_W-1:0] next_tkt_q;
	logic                hit_q;
	logic [TICKET_W-1:0] hit_tkt_q;

	// per-request results before the output register
	logic                found_q;
	logic [TICKET_W-1:0] ticket_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    front_q;

	// output register
	logic                rsp_vld_q;
	logic [KEY_W-1:0]    rsp_front_q;
	logic                rsp_fvld_q;
	logic [TICKET_W-1:0] rsp_ticket_q;
	logic                rsp_found_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	logic          accept;
	logic          scan_start;
	logic [AW-1:0] scan_addr;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	scan_res_t     scan_res;
	logic          ram_we;
	entry_t        wr_entry;
	logic          is_full;
	logic          is_empty;
	logic          out_free;
	logic [AW-1:0] head_nxt;
	logic [AW-1:0] tail_nxt;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE);
	assign scan_start = accept && ((req.cmd == CMD_ADD) || (req.cmd == CMD_QUERY));
	assign is_full    = (fill_q == CW'(DEPTH));
	assign is_empty   = (fill_q == '0);
	assign out_free   = !rsp_vld_q || rsp.ready;
	assign head_nxt   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt   = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// new entry goes in at the tail during the update step
	assign ram_we          = (state_q == ST_UPDATE) && (cmd_q == CMD_ADD) && !hit_q && !is_full;
	assign wr_entry.key    = key_q;
	assign wr_entry.ticket = next_tkt_q;

	// read port: search walks the window, otherwise it fetches the front
	assign rd_addr = (state_q == ST_SCAN) ? scan_addr : head_q;

	dftk_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	dftk_scan #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.head    (head_q),
		.fill    (fill_q),
		.key     (key_q),
		.rd_addr (scan_addr),
		.rd_data (rd_data),
		.res     (scan_res)
	);

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			next_tkt_q <= TICKET_W'(1);
			hit_q      <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			// in the output step a taken item is replaced by the next one
			if (rsp_vld_q && rsp.ready && (state_q != ST_OUT)) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					hit_q <= 1'b0;
					if (accept) begin
						state_q <= scan_start ? ST_SCAN : ST_UPDATE;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						hit_q   <= scan_res.hit;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (ram_we) begin
						next_tkt_q <= next_tkt_q + 1'b1;
						tail_q     <= tail_nxt;
						fill_q     <= CW'(fill_q + 1'b1);
					end else if ((cmd_q == CMD_REMOVE) && !is_empty) begin
						head_q <= head_nxt;
						fill_q <= CW'(fill_q - 1'b1);
					end
					state_q <= ST_FRONT_RD;
				end
				ST_FRONT_RD: begin
					state_q <= is_empty ? ST_OUT : ST_FRONT_WT;
				end
				ST_FRONT_WT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						rsp_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			key_q <= req.key & KEY_MASK;
		end
		if ((state_q == ST_SCAN) && scan_res.done) begin
			hit_tkt_q <= scan_res.ticket;
		end
		if (state_q == ST_UPDATE) begin
			case (cmd_q)
				CMD_ADD: begin
					found_q <= hit_q;
					if (hit_q) begin
						ticket_q <= hit_tkt_q;
						status_q <= STAT_IGNORED;
					end else if (is_full) begin
						ticket_q <= '0;
						status_q <= STAT_FULL;
					end else begin
						ticket_q <= next_tkt_q;
						status_q <= STAT_DONE;
					end
				end
				CMD_REMOVE: begin
					found_q  <= 1'b0;
					ticket_q <= '0;
					status_q <= is_empty ? STAT_IGNORED : STAT_DONE;
				end
				CMD_QUERY: begin
					found_q  <= hit_q;
					ticket_q <= hit_q ? hit_tkt_q : '0;
					status_q <= STAT_DONE;
				end
				default: begin
					found_q  <= 1'b0;
					ticket_q <= '0;
					status_q <= STAT_DONE;
				end
			endcase
		end
		if (state_q == ST_FRONT_RD) begin
			front_q <= '0;
		end
		if (state_q == ST_FRONT_WT) begin
			front_q <= rd_data.key;
		end
		if ((state_q == ST_OUT) && out_free) begin
			rsp_front_q  <= front_q;
			rsp_fvld_q   <= !is_empty;
			rsp_ticket_q <= ticket_q;
			rsp_found_q  <= found_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= COUNT_W'(fill_q);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.front_key   = rsp_front_q;
	assign rsp.front_valid = rsp_fvld_q;
	assign rsp.ticket      = rsp_ticket_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.count       = rsp_count_q;

endmodule
`default_nettype wire

/* rtl/core/dftk_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module dftk_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/dftk_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
module dftk_scan #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [AW-1:0]               head,
	input  wire logic [CW-1:0]               fill,
	input  wire logic [dftk_pkg::KEY_W-1:0]  key,
	output logic      [AW-1:0]               rd_addr,
	input  wire dftk_pkg::entry_t            rd_data,
	output dftk_pkg::scan_res_t              res
);
	import dftk_pkg::*;

	logic          busy_q;
	logic          pend_q;    // a read was issued last cycle
	logic [CW-1:0] cnt_q;     // reads issued so far
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_nxt;
	logic          hit_now;
	scan_res_t     res_q;

	assign ptr_nxt = (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign hit_now = pend_q && (rd_data.key == key);
	assign rd_addr = ptr_q;
	assign res     = res_q;

	// one comparison per cycle, next read overlapped with the compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			cnt_q  <= '0;
			ptr_q  <= '0;
			res_q  <= '0;
		end else begin
			res_q.done <= busy_q && !start && (hit_now || (cnt_q == fill));
			if (start) begin
				busy_q <= 1'b1;
				pend_q <= 1'b0;
				cnt_q  <= '0;
				ptr_q  <= head;
			end else if (busy_q) begin
				if (hit_now || (cnt_q == fill)) begin
					busy_q       <= 1'b0;
					pend_q       <= 1'b0;
					res_q.hit    <= hit_now;
					res_q.ticket <= rd_data.ticket;
				end else begin
					pend_q <= 1'b1;
					ptr_q  <= ptr_nxt;
					cnt_q  <= CW'(cnt_q + 1'b1);
				end
			end
		end
	end

endmodule
`default_nettype wire

/* verif/dftk_tb_pkg.sv */
`timescale 1ns / 1ps
package dftk_tb_pkg;
	import dftk_pkg::*;

	localparam int QDEPTH = 16;

	typedef struct packed {
		logic [KEY_W-1:0]    front_key;
		logic                front_valid;
		logic [TICKET_W-1:0] ticket;
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} rsp_item_t;

	// Shadow copy of the keyed queue plus the list of results still owed.
	class ticket_queue_scoreboard;
		logic [KEY_W-1:0]    slot_key    [QDEPTH];
		logic [TICKET_W-1:0] slot_ticket [QDEPTH];
		int unsigned         head;
		int unsigned         tail;
		int unsigned         fill;
		logic [TICKET_W-1:0] next_ticket;
		rsp_item_t           expected_rsp [$];
		int unsigned         errors;

		function new();
			head        = 0;
			tail        = 0;
			fill        = 0;
			next_ticket = 1;
			errors      = 0;
		endfunction

		// search the occupied window only, oldest first
		function bit find_key(logic [KEY_W-1:0] k, output int unsigned slot);
			int unsigned p;
			int unsigned n;
			p    = head;
			slot = 0;
			for (n = 0; n < fill; n++) begin
				if (slot_key[p] == k) begin
					slot = p;
					return 1'b1;
				end
				p = (p + 1) % QDEPTH;
			end
			return 1'b0;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
			rsp_item_t   r;
			int unsigned slot;
			r = '0;
			case (cmd)
				CMD_ADD: begin
					if (find_key(k, slot)) begin
						// duplicate wins over full
						r.found  = 1'b1;
						r.ticket = slot_ticket[slot];
						r.status = STAT_IGNORED;
					end else if (fill >= QDEPTH) begin
						r.status = STAT_FULL;
					end else begin
						slot_key[tail]    = k;
						slot_ticket[tail] = next_ticket;
						r.ticket          = next_ticket;
						next_ticket       = next_ticket + 1'b1;
						tail              = (tail + 1) % QDEPTH;
						fill++;
					end
				end
				CMD_REMOVE: begin
					if (fill == 0) begin
						r.status = STAT_IGNORED;
					end else begin
						head = (head + 1) % QDEPTH;
						fill--;
					end
				end
				CMD_QUERY: begin
					if (find_key(k, slot)) begin
						r.found  = 1'b1;
						r.ticket = slot_ticket[slot];
					end
				end
				default: ;
			endcase
			if (fill != 0) begin
				r.front_key   = slot_key[head];
				r.front_valid = 1'b1;
			end
			r.count = fill[COUNT_W-1:0];
			expected_rsp.insert(expected_rsp.size(), r);
		endfunction

		function void compare_field(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t e;
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
				return;
			end
			e = expected_rsp[0];
			expected_rsp.delete(0);
			compare_field("front_key", e.front_key, got.front_key);
			compare_field("front_valid", e.front_valid, got.front_valid);
			compare_field("ticket", e.ticket, got.ticket);
			compare_field("found", e.found, got.found);
			compare_field("status", e.status, got.status);
			compare_field("count", e.count, got.count);
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

endpackage

/* verif/tb_dedup_fifo_with_tickets_unit.sv */
`timescale 1ns / 1ps
// Drives the keyed ticket queue with commands on the request channel and
// checks every response item against a shadow queue held in the scoreboard.
module tb_dedup_fifo_with_tickets_unit;
	import dftk_pkg::*;
	import dftk_tb_pkg::*;

	localparam int POOL_N = 24;

	logic clk = 1'b0;
	logic arst_n;

	dftk_req_if req_ch ();
	dftk_rsp_if rsp_ch ();

	dedup_fifo_with_tickets_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	ticket_queue_scoreboard sb;

	// idling knobs: sender one is only touched by the main flow,
	// receiver ones are read at the clock edge so they change by NBA
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	logic        rx_hold;

	// small key pool so adds collide and queries hit
	logic [KEY_W-1:0] key_pool [POOL_N];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Response side: take the item when valid and ready met at this edge,
	// then pick ready for the next cycle. The long hold-off overrides all.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_result('{rsp_ch.front_key, rsp_ch.front_valid, rsp_ch.ticket,
				rsp_ch.found, rsp_ch.status, rsp_ch.count});
		rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Offer one item, with random idle cycles before it, and return at the
	// edge where it was taken.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= cmd;
		req_ch.key   <= k;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(cmd, k);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75)
			return key_pool[$urandom_range(POOL_N - 1)];
		else if (r < 85)
			return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
		else
			return KEY_W'($urandom);
	endfunction

	// Random commands with a given add/remove mix; peek takes a tenth and
	// query the rest. Fresh key pool each run.
	task automatic run_random(int unsigned n, int unsigned add_pct, int unsigned rem_pct);
		int unsigned      i;
		int unsigned      r;
		logic [CMD_W-1:0] cmd;
		for (i = 0; i < POOL_N; i++)
			key_pool[i] = KEY_W'($urandom);
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < add_pct)
				cmd = CMD_ADD;
			else if (r < add_pct + rem_pct)
				cmd = CMD_REMOVE;
			else if (r < add_pct + rem_pct + 10)
				cmd = CMD_PEEK;
			else
				cmd = CMD_QUERY;
			send_item(cmd, pick_key());
		end
	endtask

	// One idling setting: first let the queue fill, then drain it, so the
	// fill count sweeps from empty to full and back.
	task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		run_random(240, 55, 15);
		run_random(220, 25, 45);
	endtask

	initial begin
		int unsigned i;
		sb           = new();
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_PEEK;
		req_ch.key   = '0;
		rsp_ch.ready = 1'b0;
		rx_hold      = 1'b0;
		rx_stall_pct = 0;
		tx_idle_pct  = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue corner cases first.
		send_item(CMD_PEEK, 16'h0000);      // peek on empty
		send_item(CMD_REMOVE, 16'hFFFF);    // remove on empty is ignored
		send_item(CMD_QUERY, 16'h0000);     // query on empty: not found
		send_item(CMD_ADD, 16'h0000);       // lowest key, first ticket
		send_item(CMD_ADD, 16'hFFFF);       // highest key
		send_item(CMD_ADD, 16'h0000);       // duplicate: old ticket, no advance
		send_item(CMD_QUERY, 16'hFFFF);     // hit
		send_item(CMD_QUERY, 16'h1234);     // miss
		send_item(CMD_PEEK, 16'hFFFF);
		send_item(CMD_ADD, 16'hAAAA);
		send_item(CMD_ADD, 16'h5555);
		send_item(CMD_REMOVE, 16'h0000);    // front moves on
		send_item(CMD_QUERY, 16'h0000);     // removed key no longer found
		send_item(CMD_ADD, 16'h0000);       // same key again gets a new ticket
		// walk a one through the key to fill the queue up
		for (i = 0; i < 12; i++)
			send_item(CMD_ADD, KEY_W'(1) << i);
		send_item(CMD_ADD, 16'h8000);       // absent key on full queue: rejected
		send_item(CMD_ADD, 16'hAAAA);       // duplicate on full queue: ignored

		// Random phases with the four idling settings.
		run_phase(0, 0);
		run_phase(68, 0);
		run_phase(0, 68);
		run_phase(33, 33);

		// Back-pressure: receiver holds off for a long stretch while the
		// sender keeps offering, so the block fills its output and stalls.
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		run_random(60, 40, 20);

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// longest request is a full search, so allow a little over that
		repeat (60) @(posedge clk);

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dftk_pkg.sv
rtl/core/dftk_if.sv
rtl/core/dftk_ram.sv
rtl/core/dftk_scan.sv
rtl/core/dedup_fifo_with_tickets_unit.sv
verif/dftk_tb_pkg.sv
verif/tb_dedup_fifo_with_tickets_unit.sv
